@@ src/fcct_pkg.sv @@
`default_nettype none
package fcct_pkg;

    // operation codes of an input beat
    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CLOCK  = 2'd2;
    localparam logic [1:0] OP_SRESET = 2'd3;

    localparam int CH_N      = 4;
    localparam int DIV_STEPS = 8;
    localparam int IN_W      = 32;
    localparam int OUT_W     = 48;

    // control word bits
    localparam int CW_RUN     = 7;
    localparam int CW_PRESCL  = 5;
    localparam int CW_COUNTER = 3;
    localparam int CW_TC_NEXT = 2;
    localparam int CW_RELOAD  = 1;
    localparam int CW_CTRL    = 0;

    localparam logic [7:0] VEC_MASK  = 8'hF8;
    localparam logic [7:0] READ_NONE = 8'hFF;
    localparam logic [8:0] TC_ZERO   = 9'd256;

    // one input beat, operation in the low bits
    typedef struct packed {
        logic [11:0] tstates;
        logic [7:0]  data;
        logic [2:0]  channel;
        logic [1:0]  operation;
    } t_item;

    // one result beat, read_data in the low bits
    typedef struct packed {
        logic [7:0] irq_vector;
        logic [7:0] fires_ch3;
        logic [7:0] fires_ch2;
        logic [7:0] fires_ch1;
        logic [7:0] fires_ch0;
        logic [7:0] read_data;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic exec;
        logic step;
        logic update;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op_clock;
    } t_sts;

endpackage
`default_nettype wire

@@ src/fcct_ctrl.sv @@
`default_nettype none
module fcct_ctrl
    import fcct_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    input  wire   i_out_free,
    input  t_sts  i_sts,
    output logic  o_in_ready,
    output logic  o_push,
    output t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_DIV  = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;
    localparam logic [2:0] STEP_LAST = 3'(DIV_STEPS - 1);

    logic [2:0] r_state, n_state;
    logic [2:0] r_step, n_step;

    // next state
    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_step  = 3'd0;
                n_state = i_sts.op_clock ? S_DIV : S_OUT;
            end
            S_DIV: begin
                n_step = r_step + 3'd1;
                if (r_step == STEP_LAST) n_state = S_UPD;
            end
            S_UPD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (i_out_free) n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    // commands
    assign o_in_ready   = (r_state == S_IDLE);
    assign o_cmd.load   = (r_state == S_IDLE) && i_in_valid;
    assign o_cmd.exec   = (r_state == S_EXEC);
    assign o_cmd.step   = (r_state == S_DIV);
    assign o_cmd.update = (r_state == S_UPD);
    assign o_push       = (r_state == S_OUT) && i_out_free;

endmodule
`default_nettype wire

@@ src/fcct_datapath.sv @@
`default_nettype none
module fcct_datapath
    import fcct_pkg::*;
(
    input  wire     i_clk,
    input  wire     i_rst_n,
    input  t_cmd    i_cmd,
    input  t_item   i_item,
    output t_sts    o_sts,
    output t_result o_result
);

    // latched beat
    logic [1:0]  r_op;
    logic [2:0]  r_ch;
    logic [7:0]  r_data;
    logic [11:0] r_ts;

    // channel state
    logic [7:0]  r_cw   [CH_N];
    logic [7:0]  r_tc   [CH_N];
    logic [15:0] r_cnt  [CH_N];
    logic [CH_N-1:0] r_pend;
    logic [7:0]  r_vec;

    // divider lanes
    logic [CH_N-1:0] r_fpath;
    logic [7:0]  r_rem  [CH_N];
    logic [7:0]  r_quo  [CH_N];
    logic [8:0]  r_dvs  [CH_N];

    // result
    logic [7:0]  r_rd;
    logic [7:0]  r_fires [CH_N];

    logic [1:0]  sel;
    logic [7:0]  lane_n   [CH_N];
    logic [CH_N-1:0] lane_fp;
    logic [CH_N-1:0] lane_run;
    logic [7:0]  lane_m   [CH_N];
    logic [8:0]  lane_r   [CH_N];
    logic [8:0]  rem_sh   [CH_N];
    logic [CH_N-1:0] qbit;
    logic [8:0]  rem_nx   [CH_N];
    logic [8:0]  new_cnt  [CH_N];

    assign sel = r_ch[1:0];

    // latch the accepted beat
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op   <= i_item.operation;
            r_ch   <= i_item.channel;
            r_data <= i_item.data;
            r_ts   <= i_item.tstates;
        end
    end

    // per-lane tick count, fire path and division step
    always_comb begin
        for (int i = 0; i < CH_N; i++) begin
            lane_run[i] = r_cw[i][CW_RUN] && !r_cw[i][CW_COUNTER];
            lane_n[i]   = r_cw[i][CW_PRESCL] ? {4'd0, r_ts[11:8]} : r_ts[11:4];
            if (lane_n[i] == 8'd0) lane_n[i] = 8'd1;
            // counter reaches zero within this beat
            lane_fp[i]  = (r_cnt[i] != 16'd0) && (r_cnt[i] <= {8'd0, lane_n[i]});
            lane_m[i]   = lane_n[i] - r_cnt[i][7:0];
            lane_r[i]   = (r_tc[i] == 8'd0) ? TC_ZERO : {1'b0, r_tc[i]};
            rem_sh[i]   = {r_rem[i], r_quo[i][7]};
            qbit[i]     = (rem_sh[i] >= r_dvs[i]);
            rem_nx[i]   = qbit[i] ? (rem_sh[i] - r_dvs[i]) : rem_sh[i];
            new_cnt[i]  = r_dvs[i] - {1'b0, r_rem[i]};
        end
    end

    // divider lanes: quotient and remainder of the ticks left after the first fire
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < CH_N; i++) begin
            if (i_cmd.exec) begin
                r_fpath[i] <= lane_run[i] && lane_fp[i];
                r_rem[i]   <= 8'd0;
                r_quo[i]   <= lane_m[i];
                r_dvs[i]   <= lane_r[i];
            end else if (i_cmd.step) begin
                r_rem[i]   <= rem_nx[i][7:0];
                r_quo[i]   <= {r_quo[i][6:0], qbit[i]};
            end
        end
    end

    // channel registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CH_N; i++) begin
                r_cw[i]  <= 8'd0;
                r_tc[i]  <= 8'd0;
                r_cnt[i] <= 16'd0;
            end
            r_pend <= '0;
            r_vec  <= 8'd0;
        end else begin
            if (i_cmd.exec) begin
                unique case (r_op)
                    OP_WRITE: begin
                        if (!r_ch[2]) begin
                            if (r_pend[sel]) begin
                                r_tc[sel]   <= r_data;
                                r_cnt[sel]  <= (r_data == 8'd0) ? {7'd0, TC_ZERO}
                                                                : {8'd0, r_data};
                                r_pend[sel] <= 1'b0;
                            end else if (sel == 2'd0 && !r_data[CW_CTRL]) begin
                                r_vec <= r_data & VEC_MASK;
                            end else begin
                                r_cw[sel] <= r_data;
                                if (r_data[CW_TC_NEXT]) r_pend[sel] <= 1'b1;
                                if (r_data[CW_RELOAD])  r_cnt[sel]  <= {8'd0, r_tc[sel]};
                            end
                        end
                    end
                    OP_READ: begin
                    end
                    OP_CLOCK: begin
                        // lanes that do not reach zero just count down
                        for (int i = 0; i < CH_N; i++) begin
                            if (lane_run[i] && !lane_fp[i])
                                r_cnt[i] <= r_cnt[i] - {8'd0, lane_n[i]};
                        end
                    end
                    OP_SRESET: begin
                        for (int i = 0; i < CH_N; i++) begin
                            r_cw[i]  <= 8'd0;
                            r_tc[i]  <= 8'd0;
                            r_cnt[i] <= 16'd0;
                        end
                        r_pend <= '0;
                    end
                    default: begin
                    end
                endcase
            end
            // reload residue after the division
            if (i_cmd.update) begin
                for (int i = 0; i < CH_N; i++) begin
                    if (r_fpath[i]) r_cnt[i] <= {7'd0, new_cnt[i]};
                end
            end
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            if (r_op == OP_READ)
                r_rd <= r_ch[2] ? READ_NONE : r_cnt[sel][7:0];
            else
                r_rd <= 8'd0;
            for (int i = 0; i < CH_N; i++) r_fires[i] <= 8'd0;
        end else if (i_cmd.update) begin
            for (int i = 0; i < CH_N; i++)
                r_fires[i] <= r_fpath[i] ? (r_quo[i] + 8'd1) : 8'd0;
        end
    end

    assign o_sts.op_clock     = (r_op == OP_CLOCK);
    assign o_result.read_data  = r_rd;
    assign o_result.fires_ch0  = r_fires[0];
    assign o_result.fires_ch1  = r_fires[1];
    assign o_result.fires_ch2  = r_fires[2];
    assign o_result.fires_ch3  = r_fires[3];
    assign o_result.irq_vector = r_vec;

endmodule
`default_nettype wire

@@ src/four_channel_counter_timer.sv @@
// Four-channel counter/timer with the Z80 CTC programming model. Each input
// beat gives exactly one output beat. Writes, reads and soft resets go from
// acceptance through the execute state to the result register; a clock
// advance also runs the 8-step shift-subtract divider in each channel lane,
// then an update state. The divider works out how many times the counter
// reloads within the elapsed ticks. One beat is in work at a time. The next
// is accepted as soon as the result is in the output register, even while
// that register waits on o_m_tready.
`default_nettype none
module four_channel_counter_timer
    import fcct_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    output logic             o_s_tready,
    // operation[1:0], channel[4:2], data[12:5], tstates[24:13], zero fill
    input  wire  [IN_W-1:0]  i_s_tdata,
    output logic             o_m_tvalid,
    input  wire              i_m_tready,
    // read_data[7:0], fires_ch0[15:8], fires_ch1[23:16], fires_ch2[31:24],
    // fires_ch3[39:32], irq_vector[47:40]
    output logic [OUT_W-1:0] o_m_tdata
);

    t_cmd    cmd;
    t_sts    sts;
    t_item   item;
    t_result result;
    logic    push;
    logic    out_free;
    logic    r_out_valid;
    t_result r_out;

    assign item     = i_s_tdata[$bits(t_item)-1:0];
    assign out_free = !r_out_valid || i_m_tready;

    fcct_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .i_out_free (out_free),
        .i_sts      (sts),
        .o_in_ready (o_s_tready),
        .o_push     (push),
        .o_cmd      (cmd)
    );

    fcct_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (item),
        .o_sts    (sts),
        .o_result (result)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_out <= result;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out;

    // one beat in work at a time
    a_single_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("input accepted while a beat is in work");

    // a result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |-> (!r_out_valid || i_m_tready))
        else $error("result register overwritten");

    // vector keeps its low bits clear
    a_vector_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[42:40] == 3'd0))
        else $error("vector low bits set");

endmodule
`default_nettype wire

@@ dv/fcct_checker.sv @@
`default_nettype none
module fcct_checker
    import fcct_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_s_tvalid,
    input  wire              i_s_tready,
    // operation[1:0], channel[4:2], data[12:5], tstates[24:13], zero fill
    input  wire  [IN_W-1:0]  i_s_tdata,
    input  wire              i_m_tvalid,
    input  wire              i_m_tready,
    // read_data[7:0], fires_ch0[15:8], fires_ch1[23:16], fires_ch2[31:24],
    // fires_ch3[39:32], irq_vector[47:40]
    input  wire  [OUT_W-1:0] i_m_tdata,
    output int               o_fail_count,
    output int               o_pending
);

    // shadow copy of the timer lanes
    logic [7:0]  ctl_word   [CH_N];
    logic [7:0]  tconst     [CH_N];
    logic [15:0] down_cnt   [CH_N];
    logic        tc_pending [CH_N];
    logic [7:0]  vec_base;

    // results still owed by the block, oldest first
    t_result owed_results [$];

    string   field_name [0:5] = '{"read_data", "fires_ch0", "fires_ch1",
                                  "fires_ch2", "fires_ch3", "irq_vector"};
    int      fail_tally = 0;
    t_item   in_beat;
    t_result want;
    t_result got;
    logic    beat_bad;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic clear_lanes();
        for (int c = 0; c < CH_N; c++) begin
            ctl_word[c]   = '0;
            tconst[c]     = '0;
            down_cnt[c]   = '0;
            tc_pending[c] = 1'b0;
        end
    endtask

    // a zero constant stands for 256
    function automatic logic [15:0] reload_of(input int c);
        return (tconst[c] == 8'd0) ? 16'(TC_ZERO) : {8'd0, tconst[c]};
    endfunction

    // run one lane for a clock advance and count its reloads
    task automatic tick_lane(input int c, input logic [11:0] ts, output logic [7:0] fires);
        int ticks;
        fires = '0;
        if (ctl_word[c][CW_RUN] && !ctl_word[c][CW_COUNTER]) begin
            ticks = ctl_word[c][CW_PRESCL] ? int'(ts) / 256 : int'(ts) / 16;
            if (ticks == 0)
                ticks = 1;
            for (int t = 0; t < ticks; t++) begin
                down_cnt[c] = down_cnt[c] - 16'd1;
                if (down_cnt[c] == 16'd0) begin
                    down_cnt[c] = reload_of(c);
                    fires = fires + 8'd1;
                end
            end
        end
    endtask

    // work out the result of one input beat and advance the shadow state
    task automatic predict_result(input t_item it, output t_result r);
        int c;
        c = int'(it.channel);
        r = '0;
        case (it.operation)
            OP_WRITE: begin
                if (c < CH_N) begin
                    if (tc_pending[c]) begin
                        tconst[c]     = it.data;
                        down_cnt[c]   = reload_of(c);
                        tc_pending[c] = 1'b0;
                    end else if (c == 0 && !it.data[CW_CTRL]) begin
                        vec_base = it.data & VEC_MASK;
                    end else begin
                        ctl_word[c] = it.data;
                        if (it.data[CW_TC_NEXT])
                            tc_pending[c] = 1'b1;
                        if (it.data[CW_RELOAD])
                            down_cnt[c] = {8'd0, tconst[c]};
                    end
                end
            end
            OP_READ: begin
                r.read_data = (c < CH_N) ? down_cnt[c][7:0] : READ_NONE;
            end
            OP_CLOCK: begin
                tick_lane(0, it.tstates, r.fires_ch0);
                tick_lane(1, it.tstates, r.fires_ch1);
                tick_lane(2, it.tstates, r.fires_ch2);
                tick_lane(3, it.tstates, r.fires_ch3);
            end
            default: begin
                clear_lanes();
            end
        endcase
        r.irq_vector = vec_base;
    endtask

    // watch both channels at the rising edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_lanes();
            vec_base = '0;
            owed_results.delete();
        end else begin
            // output beat against the oldest prediction
            if (i_m_tvalid && i_m_tready) begin
                got = t_result'(i_m_tdata);
                if (owed_results.size() == 0) begin
                    $display("%0t: result beat with nothing owed, expected none, got %h",
                             $time, got);
                    fail_tally++;
                end else begin
                    want     = owed_results.pop_front();
                    beat_bad = 1'b0;
                    for (int k = 0; k < 6; k++) begin
                        if (want[8*k +: 8] !== got[8*k +: 8]) begin
                            $display("%0t: %s expected %02h got %02h", $time,
                                     field_name[k], want[8*k +: 8], got[8*k +: 8]);
                            beat_bad = 1'b1;
                        end
                    end
                    if (beat_bad)
                        fail_tally++;
                end
            end
            // input beat gives one prediction
            if (i_s_tvalid && i_s_tready) begin
                in_beat = t_item'(i_s_tdata[$bits(t_item)-1:0]);
                predict_result(in_beat, want);
                owed_results.push_back(want);
            end
        end
        o_fail_count <= fail_tally;
        o_pending    <= owed_results.size();
    end

endmodule
`default_nettype wire

@@ dv/tb.sv @@
`default_nettype none
module tb;
    import fcct_pkg::*;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic [IN_W-1:0]  s_tdata  = '0;
    logic             m_tready = 1'b0;
    wire              s_tready;
    wire              m_tvalid;
    wire  [OUT_W-1:0] m_tdata;
    int               fail_count;
    int               pending;

    int items_sent = 0;
    bit quiet      = 1'b0;

    initial begin
        forever #6 clk = ~clk;
    end

    four_channel_counter_timer uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    fcct_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // hard stop if the block hangs
    initial begin
        #12_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge clk);
            m_tready <= quiet || ($urandom_range(0, 99) >= 22);
        end
    end

    // offer one beat, with random gaps, and hold it until taken
    task automatic drive_beat(input t_item it);
        @(negedge clk);
        while (!quiet && $urandom_range(0, 99) < 22) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(it);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
        quiet = (items_sent >= 700 && items_sent < 1000);
    endtask

    task automatic put(input logic [1:0] op, input logic [2:0] ch, input logic [7:0] d,
                       input logic [11:0] ts);
        t_item it;
        it.operation = op;
        it.channel   = ch;
        it.data      = d;
        it.tstates   = ts;
        drive_beat(it);
    endtask

    // control word followed, when asked for, by its time constant
    task automatic program_lane();
        logic [2:0] ch;
        logic [7:0] cw;
        logic [7:0] tc;
        ch              = 3'($urandom_range(0, 3));
        cw              = 8'($urandom);
        cw[CW_CTRL]     = 1'b1;
        cw[CW_RUN]      = ($urandom_range(0, 99) < 90);
        cw[CW_COUNTER]  = ($urandom_range(0, 99) < 10);
        cw[CW_TC_NEXT]  = ($urandom_range(0, 99) < 85);
        if ($urandom_range(0, 99) < 70)
            tc = 8'($urandom_range(0, 24));
        else
            tc = 8'($urandom);
        put(OP_WRITE, ch, cw, 12'($urandom));
        if (cw[CW_TC_NEXT])
            put(OP_WRITE, ch, tc, 12'($urandom));
    endtask

    initial begin
        int         roll;
        logic [11:0] ts;

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;

        // directed: reads after reset, wide channel numbers, vector
        put(OP_READ,   3'd0, 8'h00, 12'h000);
        put(OP_READ,   3'd7, 8'hFF, 12'hFFF);
        put(OP_WRITE,  3'd0, 8'hFE, 12'h000);
        put(OP_WRITE,  3'd5, 8'h87, 12'hFFF);
        put(OP_READ,   3'd4, 8'h00, 12'h000);
        // channel 0 running with constant zero, then 1 and 255 ticks
        put(OP_WRITE,  3'd0, 8'h87, 12'h000);
        put(OP_WRITE,  3'd0, 8'h00, 12'h000);
        put(OP_CLOCK,  3'd0, 8'h00, 12'h000);
        put(OP_CLOCK,  3'd0, 8'h00, 12'hFFF);
        put(OP_READ,   3'd0, 8'h00, 12'h000);
        // prescaled channel 1 with a short constant
        put(OP_WRITE,  3'd1, 8'hA5, 12'h000);
        put(OP_WRITE,  3'd1, 8'h03, 12'h000);
        put(OP_CLOCK,  3'd1, 8'h00, 12'hFFF);
        // counter mode on channel 2 never ticks
        put(OP_WRITE,  3'd2, 8'h8D, 12'h000);
        put(OP_WRITE,  3'd2, 8'hFF, 12'h000);
        // raw reload of zero on channel 3 wraps on the first tick
        put(OP_WRITE,  3'd3, 8'h83, 12'h000);
        put(OP_CLOCK,  3'd3, 8'h00, 12'h01F);
        put(OP_READ,   3'd3, 8'h00, 12'h000);
        put(OP_READ,   3'd2, 8'h00, 12'h000);
        // pending constant beats a vector-looking byte
        put(OP_WRITE,  3'd0, 8'h05, 12'h000);
        put(OP_WRITE,  3'd0, 8'h10, 12'h000);
        put(OP_CLOCK,  3'd0, 8'h00, 12'h0FF);
        // soft reset keeps the vector
        put(OP_SRESET, 3'd6, 8'hFF, 12'hFFF);
        put(OP_READ,   3'd1, 8'h00, 12'h000);
        put(OP_CLOCK,  3'd0, 8'h00, 12'hFFF);

        // random part, mostly programmed lanes and short clock advances
        while (items_sent < 1600) begin
            roll = $urandom_range(0, 99);
            if (roll < 35) begin
                if ($urandom_range(0, 99) < 70)
                    ts = 12'($urandom_range(0, 63));
                else if ($urandom_range(0, 99) < 50)
                    ts = 12'($urandom_range(0, 400));
                else
                    ts = 12'($urandom);
                put(OP_CLOCK, 3'($urandom), 8'($urandom), ts);
            end else if (roll < 55) begin
                if ($urandom_range(0, 99) < 85)
                    put(OP_READ, 3'($urandom_range(0, 3)), 8'($urandom), 12'($urandom));
                else
                    put(OP_READ, 3'($urandom), 8'($urandom), 12'($urandom));
            end else if (roll < 88) begin
                program_lane();
            end else if (roll < 92) begin
                put(OP_WRITE, 3'd0, 8'($urandom) & 8'hFE, 12'($urandom));
            end else if (roll < 94) begin
                put(OP_SRESET, 3'($urandom), 8'($urandom), 12'($urandom));
            end else begin
                put(OP_WRITE, 3'($urandom), 8'($urandom), 12'($urandom));
            end
        end

        @(negedge clk);
        s_tvalid <= 1'b0;

        // drain, then let the pipeline settle
        while (pending != 0)
            @(negedge clk);
        repeat (30) @(negedge clk);

        if (fail_count == 0 && pending == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
`default_nettype wire

@@ filelist.f @@
src/fcct_pkg.sv
src/fcct_ctrl.sv
src/fcct_datapath.sv
src/four_channel_counter_timer.sv
dv/fcct_checker.sv
dv/tb.sv
